### hw/rtl/i2c_master_bit_engine_macros.svh
// assertion helpers used by i2cm_engine.sv
`ifndef I2C_MASTER_BIT_ENGINE_MACROS_SVH
`define I2C_MASTER_BIT_ENGINE_MACROS_SVH

// same-cycle implication, sampled on the block clock
`define I2CM_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on the block clock
`define I2CM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/i2cm_pkg.sv
package i2cm_pkg;

   typedef enum logic [2:0] {
      OP_START    = 3'd0,
      OP_STOP     = 3'd1,
      OP_WRITE    = 3'd2,
      OP_READ     = 3'd3,
      OP_ACK      = 3'd4,
      OP_NACK     = 3'd5,
      OP_WAIT_ACK = 3'd6,
      OP_RESERVED = 3'd7
   } op_type;

   // phase index within a command sequence
   localparam logic [2:0] STEP_FIRST  = 3'd0;
   localparam logic [2:0] STEP_SECOND = 3'd1;
   localparam logic [2:0] STEP_THIRD  = 3'd2;
   localparam logic [2:0] STEP_FOURTH = 3'd3;
   localparam logic [2:0] STEP_FIFTH  = 3'd4;

   localparam logic [7:0] PHASE_TICKS_RESET = 8'd10;
   localparam logic [3:0] BYTE_BITS         = 4'd8;

   typedef struct packed {
      logic       cmd_valid;
      logic [2:0] op;
      logic [7:0] wr_byte;
      logic       sda_in;
   } item_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rd_byte;
      logic       ack_bit;
   } result_type;

   typedef struct packed {
      logic scl;
      logic sda;
   } pins_type;

   // pin levels set on entry to a phase
   function automatic pins_type phase_pins(op_type cmd, logic [2:0] step,
                                           logic data_msb, pins_type cur);
      pins_type p;
      p = cur;
      case (cmd)
         OP_START: begin
            if (step == STEP_FIRST) begin
               p.scl = 1'b1;
               p.sda = 1'b1;
            end else if (step == STEP_SECOND) begin
               p.sda = 1'b0;
            end else begin
               p.scl = 1'b0;
            end
         end
         OP_STOP: begin
            if (step == STEP_FIRST) begin
               p.scl = 1'b1;
               p.sda = 1'b0;
            end else begin
               p.sda = 1'b1;
            end
         end
         OP_WRITE: begin
            if (step == STEP_FIRST) p.sda = data_msb;
            else if (step == STEP_SECOND) p.scl = 1'b1;
            else if (step == STEP_THIRD) p.scl = 1'b0;
            else p.sda = 1'b1;
         end
         OP_ACK, OP_NACK: begin
            if (step == STEP_FIRST) p.sda = (cmd == OP_NACK);
            else if (step == STEP_SECOND) p.scl = 1'b1;
            else if (step == STEP_THIRD) p.scl = 1'b0;
            else p.sda = 1'b1;
         end
         default: begin
            // read byte and wait ack: release both, then pull scl low
            if (step == STEP_FIRST) begin
               p.scl = 1'b1;
               p.sda = 1'b1;
            end else begin
               p.scl = 1'b0;
            end
         end
      endcase
      return p;
   endfunction

   // phase count of the fixed-length commands
   function automatic logic [2:0] last_step(op_type cmd);
      logic [2:0] n;
      case (cmd)
         OP_START:    n = STEP_FOURTH;
         OP_STOP:     n = STEP_THIRD;
         OP_ACK:      n = STEP_FIFTH;
         OP_WAIT_ACK: n = STEP_THIRD;
         default:     n = STEP_FOURTH;
      endcase
      return n;
   endfunction

endpackage

### hw/rtl/i2cm_if.sv
interface i2cm_req_if;
   logic       valid;
   logic       ready;
   logic       cmd_valid;
   logic [2:0] op;
   logic [7:0] wr_byte;
   logic       sda_in;

   modport source (output valid, cmd_valid, op, wr_byte, sda_in, input ready);
   modport sink (input valid, cmd_valid, op, wr_byte, sda_in, output ready);
endinterface

interface i2cm_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_out;
   logic       sda_out;
   logic       busy_res;
   logic       done_res;
   logic [7:0] rd_byte;
   logic       ack_bit;

   modport source (output valid, scl_out, sda_out, busy_res, done_res, rd_byte, ack_bit,
                   input ready);
   modport sink (input valid, scl_out, sda_out, busy_res, done_res, rd_byte, ack_bit,
                 output ready);
endinterface

### hw/rtl/i2cm_engine.sv
`include "i2c_master_bit_engine_macros.svh"

module i2cm_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  i2cm_pkg::item_type   item,
   input  logic [7:0]           phase_ticks,
   output i2cm_pkg::result_type result
);
   import i2cm_pkg::*;

   op_type     cmd_ff, cmd_in, item_op;
   logic [2:0] step_ff, step_in, step_inc;
   logic [3:0] bit_ff, bit_in, bit_inc;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] tick_ff, tick_in, tick_dec, tick_load;
   pins_type   pins_ff, pins_in;
   logic       ack_ff, ack_in;
   logic [7:0] rd_ff, rd_in;
   logic       busy_ff, busy_in;
   logic       done, enter, finish;

   assign item_op   = op_type'(item.op);
   assign step_inc  = step_ff + 3'd1;
   assign bit_inc   = bit_ff + 4'd1;
   assign tick_dec  = tick_ff - 8'd1;
   assign tick_load = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;

   always_comb begin
      cmd_in   = cmd_ff;
      step_in  = step_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      tick_in  = tick_ff;
      pins_in  = pins_ff;
      ack_in   = ack_ff;
      rd_in    = rd_ff;
      busy_in  = busy_ff;
      done     = 1'b0;
      enter    = 1'b0;
      finish   = 1'b0;
      if (!busy_ff) begin
         if (item.cmd_valid && item_op != OP_RESERVED) begin
            cmd_in   = item_op;
            step_in  = STEP_FIRST;
            bit_in   = 4'd0;
            shift_in = (item_op == OP_WRITE) ? item.wr_byte : 8'd0;
            busy_in  = 1'b1;
            enter    = 1'b1;
         end
      end else begin
         tick_in = tick_dec;
         if (tick_dec == 8'd0) begin
            case (cmd_ff)
               OP_WRITE: begin
                  if (step_ff == STEP_THIRD) begin
                     shift_in = {shift_ff[6:0], 1'b0};
                     bit_in   = bit_inc;
                     step_in  = (bit_inc < BYTE_BITS) ? STEP_FIRST : STEP_FOURTH;
                  end else if (step_ff == STEP_FOURTH) begin
                     finish = 1'b1;
                  end else begin
                     step_in = step_inc;
                  end
               end
               OP_READ: begin
                  if (step_ff == STEP_FIRST) begin
                     // sample on the last tick of the scl-high phase
                     shift_in = {shift_ff[6:0], item.sda_in};
                     step_in  = STEP_SECOND;
                  end else begin
                     bit_in = bit_inc;
                     if (bit_inc < BYTE_BITS) begin
                        step_in = STEP_FIRST;
                     end else begin
                        rd_in  = shift_ff;
                        finish = 1'b1;
                     end
                  end
               end
               default: begin
                  if (cmd_ff == OP_WAIT_ACK && step_ff == STEP_FIRST) ack_in = item.sda_in;
                  if (step_inc >= last_step(cmd_ff)) finish = 1'b1;
                  else step_in = step_inc;
               end
            endcase
            if (finish) begin
               busy_in = 1'b0;
               done    = 1'b1;
               step_in = STEP_FIRST;
            end else begin
               enter = 1'b1;
            end
         end
      end
      if (enter) begin
         pins_in = phase_pins(cmd_in, step_in, shift_in[7], pins_ff);
         tick_in = tick_load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff   <= OP_START;
         step_ff  <= STEP_FIRST;
         bit_ff   <= 4'd0;
         shift_ff <= 8'd0;
         tick_ff  <= 8'd0;
         pins_ff  <= '{scl: 1'b1, sda: 1'b1};
         ack_ff   <= 1'b0;
         rd_ff    <= 8'd0;
         busy_ff  <= 1'b0;
      end else if (advance) begin
         cmd_ff   <= cmd_in;
         step_ff  <= step_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         tick_ff  <= tick_in;
         pins_ff  <= pins_in;
         ack_ff   <= ack_in;
         rd_ff    <= rd_in;
         busy_ff  <= busy_in;
      end
   end

   assign result.scl_out  = pins_in.scl;
   assign result.sda_out  = pins_in.sda;
   assign result.busy_res = busy_in;
   assign result.done_res = done;
   assign result.rd_byte  = rd_in;
   assign result.ack_bit  = ack_in;

   `I2CM_ASSERT_SAME(a_busy_tick, busy_ff, tick_ff != 8'd0, "busy with empty phase counter")
   `I2CM_ASSERT_SAME(a_idle_step, !busy_ff, step_ff == STEP_FIRST, "idle engine off first phase")
   `I2CM_ASSERT_SAME(a_bit_range, busy_ff, bit_ff <= BYTE_BITS, "bit counter past a byte")
   `I2CM_ASSERT_NEXT(a_start_busy,
      advance && !busy_ff && item.cmd_valid && item_op != OP_RESERVED,
      busy_ff, "accepted command did not start")
endmodule

### hw/rtl/i2c_master_bit_engine.sv
// channel    dir  handshake            payload
// req_chan   in   valid / ready        cmd_valid, op, wr_byte, sda_in
// rsp_chan   out  valid / ready        scl_out, sda_out, busy_res, done_res, rd_byte, ack_bit
// csr_*      in   csr_valid/csr_ready  csr_wdata (phase_ticks)
//
// one item is one tick of the bit engine; one item in, one result out, one per cycle while rsp_chan does not stall
// an item is held in the input register until the engine steps on it, then its result is registered
// the engine state and the result register update together, so items chain back to back
// reset is synchronous, engine comes up idle with both lines released, phase_ticks = 10
// a stalled rsp_chan holds the result; one more item is still taken into the input register

module i2c_master_bit_engine (
   input  logic        clock,
   input  logic        reset,
   i2cm_req_if.sink    req_chan,
   i2cm_rsp_if.source  rsp_chan,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_wdata
);
   import i2cm_pkg::*;

   logic       item_valid_ff, item_valid_in;
   item_type   item_ff, item_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type result_ff, result;
   logic [7:0] phase_ticks_ff;
   logic       out_free, advance, req_accept;

   // output register free when empty or being drained this cycle
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   // engine steps when the input register holds an item and the result can move on
   assign advance        = item_valid_ff && out_free;
   assign req_chan.ready = !item_valid_ff || out_free;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign csr_ready      = 1'b1;

   assign item_in.cmd_valid = req_chan.cmd_valid;
   assign item_in.op        = req_chan.op;
   assign item_in.wr_byte   = req_chan.wr_byte;
   assign item_in.sda_in    = req_chan.sda_in;

   assign item_valid_in = req_accept ? 1'b1 : (advance ? 1'b0 : item_valid_ff);
   assign rsp_valid_in  = advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   // control state and the timing register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         phase_ticks_ff <= PHASE_TICKS_RESET;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid) phase_ticks_ff <= csr_wdata;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_accept) item_ff <= item_in;
      if (advance) result_ff <= result;
   end

   // scl/sda phase sequencer, one tick per advance
   i2cm_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .item        (item_ff),
      .phase_ticks (phase_ticks_ff),
      .result      (result)
   );

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.scl_out  = result_ff.scl_out;
   assign rsp_chan.sda_out  = result_ff.sda_out;
   assign rsp_chan.busy_res = result_ff.busy_res;
   assign rsp_chan.done_res = result_ff.done_res;
   assign rsp_chan.rd_byte  = result_ff.rd_byte;
   assign rsp_chan.ack_bit  = result_ff.ack_bit;
endmodule

### tb/tb_i2c_master_bit_engine.sv
`timescale 1ns / 100ps

module tb_i2c_master_bit_engine;
   import i2cm_pkg::*;

   typedef enum logic [2:0] {
      FILL_NONE,
      FILL_LOW,
      FILL_HIGH,
      FILL_RAND,
      FILL_POKE
   } fill_type;

   typedef enum logic {
      ROW_CFG,
      ROW_CMD
   } row_type;

   typedef struct {
      row_type    kind;
      logic [7:0] cfg_val;
      item_type   it;
      fill_type   fill;
      logic       has_exp;
      result_type exp;
   } plan_row_type;

   localparam int ITEM_TARGET = 650;

   logic clock;
   logic reset;
   logic csr_valid;
   logic csr_ready;
   logic [7:0] csr_wdata;

   i2cm_req_if req_bus ();
   i2cm_rsp_if rsp_bus ();

   i2c_master_bit_engine dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   // engine copy used for prediction
   logic [7:0] hold_ticks;
   op_type     eng_cmd;
   logic [2:0] eng_step;
   logic [3:0] eng_bits;
   logic [7:0] eng_shift;
   logic [7:0] eng_ticks;
   logic       eng_scl;
   logic       eng_sda;
   logic       eng_ack;
   logic [7:0] eng_rd;
   logic       eng_busy;

   result_type   due_results[$];
   plan_row_type script[$];
   int           mismatches = 0;
   int           items_sent = 0;
   bit           quiet = 0;
   int unsigned  stall_left = 0;

   initial begin
      clock = 1'b0;
      forever begin
         #5 clock = 1'b1;
         #5 clock = 1'b0;
      end
   end

   initial begin
      #20_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // pin levels of the phase just entered, and its hold restarted
   task automatic enter_phase();
      case (eng_cmd)
         OP_START: begin
            if (eng_step == STEP_FIRST) begin
               eng_scl = 1'b1;
               eng_sda = 1'b1;
            end else if (eng_step == STEP_SECOND) begin
               eng_sda = 1'b0;
            end else begin
               eng_scl = 1'b0;
            end
         end
         OP_STOP: begin
            if (eng_step == STEP_FIRST) begin
               eng_sda = 1'b0;
               eng_scl = 1'b1;
            end else begin
               eng_sda = 1'b1;
            end
         end
         OP_WRITE, OP_ACK, OP_NACK: begin
            if (eng_step == STEP_FIRST) begin
               if (eng_cmd == OP_WRITE) eng_sda = eng_shift[7];
               else eng_sda = (eng_cmd == OP_NACK);
            end else if (eng_step == STEP_SECOND) begin
               eng_scl = 1'b1;
            end else if (eng_step == STEP_THIRD) begin
               eng_scl = 1'b0;
            end else begin
               eng_sda = 1'b1;
            end
         end
         default: begin
            if (eng_step == STEP_FIRST) begin
               eng_sda = 1'b1;
               eng_scl = 1'b1;
            end else begin
               eng_scl = 1'b0;
            end
         end
      endcase
      eng_ticks = (hold_ticks == 8'd0) ? 8'd1 : hold_ticks;
   endtask

   // one tick of the engine: state update and the result it shows
   task automatic advance_engine(input item_type it, output result_type r);
      logic       fin;
      logic       done;
      logic [2:0] phases;
      done = 1'b0;
      fin = 1'b0;
      if (!eng_busy) begin
         if (it.cmd_valid && it.op != OP_RESERVED) begin
            eng_cmd = op_type'(it.op);
            eng_step = STEP_FIRST;
            eng_bits = 4'd0;
            eng_shift = (it.op == OP_WRITE) ? it.wr_byte : 8'h00;
            eng_busy = 1'b1;
            enter_phase();
         end
      end else begin
         eng_ticks = eng_ticks - 8'd1;
         if (eng_ticks == 8'd0) begin
            case (eng_cmd)
               OP_WRITE: begin
                  if (eng_step == STEP_THIRD) begin
                     eng_shift = eng_shift << 1;
                     eng_bits = eng_bits + 4'd1;
                     eng_step = (eng_bits < BYTE_BITS) ? STEP_FIRST : STEP_FOURTH;
                  end else if (eng_step == STEP_FOURTH) begin
                     fin = 1'b1;
                  end else begin
                     eng_step = eng_step + 3'd1;
                  end
               end
               OP_READ: begin
                  if (eng_step == STEP_FIRST) begin
                     eng_shift = {eng_shift[6:0], it.sda_in};
                     eng_step = STEP_SECOND;
                  end else begin
                     eng_bits = eng_bits + 4'd1;
                     if (eng_bits < BYTE_BITS) begin
                        eng_step = STEP_FIRST;
                     end else begin
                        eng_rd = eng_shift;
                        fin = 1'b1;
                     end
                  end
               end
               default: begin
                  // phase counts of the fixed sequences
                  case (eng_cmd)
                     OP_START: phases = 3'd3;
                     OP_STOP:  phases = 3'd2;
                     OP_ACK:   phases = 3'd4;
                     OP_NACK:  phases = 3'd3;
                     default:  phases = 3'd2;
                  endcase
                  if (eng_cmd == OP_WAIT_ACK && eng_step == STEP_FIRST) eng_ack = it.sda_in;
                  if (eng_step + 3'd1 >= phases) fin = 1'b1;
                  else eng_step = eng_step + 3'd1;
               end
            endcase
            if (fin) begin
               eng_busy = 1'b0;
               done = 1'b1;
               eng_step = STEP_FIRST;
            end else begin
               enter_phase();
            end
         end
      end
      r.scl_out = eng_scl;
      r.sda_out = eng_sda;
      r.busy_res = eng_busy;
      r.done_res = done;
      r.rd_byte = eng_rd;
      r.ack_bit = eng_ack;
   endtask

   // present one item, wait for it to be taken, record what it should produce
   task automatic push_tick(input item_type it, input logic has_exp, input result_type exp);
      result_type r;
      if (!quiet && $urandom_range(0, 9) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.cmd_valid <= it.cmd_valid;
      req_bus.op <= it.op;
      req_bus.wr_byte <= it.wr_byte;
      req_bus.sda_in <= it.sda_in;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      advance_engine(it, r);
      due_results.push_back(has_exp ? exp : r);
      items_sent++;
   endtask

   function automatic item_type make_filler(input fill_type fill);
      item_type it;
      it.cmd_valid = (fill == FILL_POKE) ? 1'($urandom_range(0, 1)) : 1'b0;
      it.op = 3'($urandom_range(0, 7));
      it.wr_byte = 8'($urandom_range(0, 255));
      case (fill)
         FILL_LOW:  it.sda_in = 1'b0;
         FILL_HIGH: it.sda_in = 1'b1;
         default:   it.sda_in = 1'($urandom_range(0, 1));
      endcase
      return it;
   endfunction

   // the command item; unless FILL_NONE, ticks until the engine is idle again
   task automatic run_command(input item_type it, input fill_type fill,
                              input logic has_exp, input result_type exp);
      push_tick(it, has_exp, exp);
      if (fill != FILL_NONE) begin
         while (eng_busy) push_tick(make_filler(fill), 1'b0, exp);
      end
   endtask

   task automatic issue(input op_type op, input logic [7:0] wr, input fill_type fill);
      item_type   it;
      result_type none;
      none = '0;
      // a few idle ticks between commands now and then
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 3)) push_tick(make_filler(FILL_RAND), 1'b0, none);
      end
      it.cmd_valid = 1'b1;
      it.op = op;
      it.wr_byte = wr;
      it.sda_in = 1'($urandom_range(0, 1));
      run_command(it, fill, 1'b0, none);
   endtask

   task automatic write_ticks(input logic [7:0] value);
      req_bus.valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      hold_ticks = value;
   endtask

   task automatic plan_cfg(input logic [7:0] value);
      plan_row_type row;
      row = '{kind: ROW_CFG, cfg_val: value, it: '0, fill: FILL_NONE, has_exp: 1'b0, exp: '0};
      script.push_back(row);
   endtask

   task automatic plan_cmd(input logic v, input op_type op, input logic [7:0] wr,
                           input fill_type fill, input logic has_exp, input result_type exp);
      plan_row_type row;
      row.kind = ROW_CMD;
      row.cfg_val = 8'd0;
      row.it.cmd_valid = v;
      row.it.op = op;
      row.it.wr_byte = wr;
      row.it.sda_in = 1'b1;
      row.fill = fill;
      row.has_exp = has_exp;
      row.exp = exp;
      script.push_back(row);
   endtask

   function automatic fill_type pick_fill();
      return ($urandom_range(0, 3) == 0) ? FILL_POKE : FILL_RAND;
   endfunction

   // start, one or two bytes read or written, stop; now and then a stray command
   task automatic random_transfer();
      int   nbytes;
      logic last;
      if ($urandom_range(0, 5) == 0) begin
         issue(op_type'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), pick_fill());
         return;
      end
      issue(OP_START, 8'($urandom_range(0, 255)), pick_fill());
      nbytes = $urandom_range(1, 2);
      for (int k = 0; k < nbytes; k++) begin
         last = (k == nbytes - 1);
         if ($urandom_range(0, 1) == 0) begin
            issue(OP_WRITE, 8'($urandom_range(0, 255)), pick_fill());
            issue(OP_WAIT_ACK, 8'($urandom_range(0, 255)), pick_fill());
         end else begin
            issue(OP_READ, 8'($urandom_range(0, 255)), pick_fill());
            if (last ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 4) == 0))
               issue(OP_NACK, 8'($urandom_range(0, 255)), pick_fill());
            else
               issue(OP_ACK, 8'($urandom_range(0, 255)), pick_fill());
         end
      end
      issue(OP_STOP, 8'($urandom_range(0, 255)), pick_fill());
   endtask

   // result checking against the oldest expectation
   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         $display("%0t %s expected %0h actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = {rsp_bus.scl_out, rsp_bus.sda_out, rsp_bus.busy_res, rsp_bus.done_res,
                rsp_bus.rd_byte, rsp_bus.ack_bit};
         if (due_results.size() == 0) begin
            $display("%0t unexpected item expected none actual %h", $time, got);
            mismatches++;
         end else begin
            want = due_results.pop_front();
            check_field("scl_out", 8'(want.scl_out), 8'(got.scl_out));
            check_field("sda_out", 8'(want.sda_out), 8'(got.sda_out));
            check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
            check_field("done_res", 8'(want.done_res), 8'(got.done_res));
            check_field("rd_byte", want.rd_byte, got.rd_byte);
            check_field("ack_bit", 8'(want.ack_bit), 8'(got.ack_bit));
         end
      end
   end

   // receiver stalls in bursts
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left = stall_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 16) - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   initial begin
      result_type  idle_res;
      result_type  none;
      logic [7:0]  phase_cfg[6];
      int          per_phase;
      int          phase_end;
      idle_res = '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0};
      none = '0;

      reset = 1'b1;
      csr_valid = 1'b0;
      csr_wdata = 8'd0;
      req_bus.valid = 1'b0;
      req_bus.cmd_valid = 1'b0;
      req_bus.op = OP_START;
      req_bus.wr_byte = 8'd0;
      req_bus.sda_in = 1'b1;
      rsp_bus.ready = 1'b0;

      hold_ticks = PHASE_TICKS_RESET;
      eng_cmd = OP_START;
      eng_step = STEP_FIRST;
      eng_bits = 4'd0;
      eng_shift = 8'd0;
      eng_ticks = 8'd0;
      eng_scl = 1'b1;
      eng_sda = 1'b1;
      eng_ack = 1'b0;
      eng_rd = 8'd0;
      eng_busy = 1'b0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed rows: reset hold, ignored code, busy pokes, read/write extremes
      plan_cmd(1'b0, OP_START, 8'h00, FILL_NONE, 1'b1, idle_res);
      plan_cmd(1'b1, OP_RESERVED, 8'hFF, FILL_NONE, 1'b1, idle_res);
      plan_cmd(1'b1, OP_START, 8'h00, FILL_RAND, 1'b1,
               '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0});
      plan_cmd(1'b1, OP_STOP, 8'h00, FILL_POKE, 1'b1,
               '{1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0});
      plan_cfg(8'd1);
      plan_cmd(1'b1, OP_START, 8'h00, FILL_RAND, 1'b0, none);
      plan_cmd(1'b1, OP_WRITE, 8'h00, FILL_RAND, 1'b0, none);
      plan_cmd(1'b1, OP_WAIT_ACK, 8'h00, FILL_LOW, 1'b0, none);
      plan_cmd(1'b1, OP_WRITE, 8'hFF, FILL_POKE, 1'b0, none);
      plan_cmd(1'b1, OP_WAIT_ACK, 8'h00, FILL_HIGH, 1'b0, none);
      plan_cmd(1'b1, OP_READ, 8'hFF, FILL_LOW, 1'b0, none);
      plan_cmd(1'b1, OP_ACK, 8'h00, FILL_RAND, 1'b0, none);
      plan_cmd(1'b1, OP_READ, 8'h00, FILL_HIGH, 1'b0, none);
      plan_cmd(1'b1, OP_NACK, 8'h00, FILL_RAND, 1'b0, none);
      plan_cmd(1'b1, OP_RESERVED, 8'h5A, FILL_NONE, 1'b0, none);
      plan_cmd(1'b1, OP_START, 8'h00, FILL_RAND, 1'b0, none);
      plan_cmd(1'b1, OP_WRITE, 8'hA5, FILL_POKE, 1'b0, none);
      plan_cmd(1'b1, OP_STOP, 8'h00, FILL_RAND, 1'b0, none);
      plan_cfg(8'd0);
      plan_cmd(1'b1, OP_START, 8'h00, FILL_RAND, 1'b0, none);
      plan_cmd(1'b1, OP_READ, 8'h00, FILL_RAND, 1'b0, none);
      plan_cmd(1'b1, OP_NACK, 8'h00, FILL_POKE, 1'b0, none);
      plan_cmd(1'b1, OP_STOP, 8'h00, FILL_RAND, 1'b0, none);

      foreach (script[i]) begin
         if (script[i].kind == ROW_CFG)
            write_ticks(script[i].cfg_val);
         else
            run_command(script[i].it, script[i].fill, script[i].has_exp, script[i].exp);
      end

      // long hold: short commands only
      write_ticks(8'd16);
      issue(OP_START, 8'h00, FILL_RAND);
      issue(OP_WAIT_ACK, 8'h00, FILL_RAND);
      issue(OP_STOP, 8'h00, FILL_RAND);

      // random transfers over several hold settings, the last with no stalls
      phase_cfg = '{8'd2, 8'd1, 8'($urandom_range(1, 2)), 8'd1, 8'd0,
                    8'($urandom_range(0, 2))};
      per_phase = (items_sent < ITEM_TARGET) ? (ITEM_TARGET - items_sent) / 6 : 0;
      for (int p = 0; p < 6; p++) begin
         write_ticks(phase_cfg[p]);
         if (p == 5) quiet = 1;
         phase_end = items_sent + per_phase;
         while (items_sent < phase_end) random_transfer();
      end

      req_bus.valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
